// File: src/fba_pkg.sv
// package for the flow byte accounting unit
// types, constants and controller states; no dependencies
`timescale 1ns / 1ps
package fba_pkg;
   localparam int TableDepthDefault = 65536;
   localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
   localparam logic [7:0] ProtoTcp = 8'd6;
   localparam logic [7:0] ProtoUdp = 8'd17;
   localparam logic [3:0] IpVersion = 4'd4;
   localparam logic [6:0] EtherLen = 7'd14;
   localparam logic [6:0] OffsetMax = 7'd127;

   typedef enum logic [1:0] {
      STATUS_ADDED = 2'd0,
      STATUS_NEW = 2'd1,
      STATUS_IGNORED = 2'd2,
      STATUS_FULL = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_PARSE,
      ST_READ,
      ST_WAIT,
      ST_CHECK,
      ST_RESULT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take_byte;
      logic scan_start;
      logic scan_next;
      logic write_add;
      logic write_new;
      logic load_result;
      logic clear_parse;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic usable;
      logic hit;
      logic scan_end;
      logic full;
   } stat_type;
endpackage

// File: src/fba_datapath.sv
// datapath: header parser, flow table memory, scan index and result register
// depends on fba_pkg
`timescale 1ns / 1ps
module fba_datapath
   import fba_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        mode,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [7:0]  data_byte,
   input  logic        first_byte,
   input  logic [63:0] group_id,
   input  logic [19:0] packet_length,
   input  logic        direction,
   output logic [1:0]  res_status,
   output logic [63:0] res_total,
   output logic [16:0] res_used
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = 64 + 64 + 33 + 64;

   logic [6:0] offset_ff, offset_in;
   logic [15:0] etype_ff, etype_in;
   logic [7:0] vl_ff, vl_in, proto_ff, proto_in;
   logic [31:0] saddr_ff, saddr_in, daddr_ff, daddr_in;
   logic [15:0] sport_ff, sport_in, dport_ff, dport_in;
   logic [63:0] group_ff;
   logic [19:0] length_ff;
   logic dir_ff;
   logic [CW-1:0] count_ff, idx_ff;
   logic [EW-1:0] mem [TABLE_DEPTH];
   logic [EW-1:0] rd_ff;
   logic [1:0] status_ff;
   logic [63:0] total_ff;
   logic usable, hit, scan_end, full;

   // per-byte parse on the offset, with held fields reloaded on first byte
   logic [6:0] pos, base, q, ihl_b, t;
   logic [7:0] vl_cur;
   always_comb begin
      pos = first_byte ? 7'd0 : offset_ff;
      etype_in = first_byte ? 16'd0 : etype_ff;
      vl_in = first_byte ? 8'd0 : vl_ff;
      proto_in = first_byte ? 8'd0 : proto_ff;
      saddr_in = first_byte ? 32'd0 : saddr_ff;
      daddr_in = first_byte ? 32'd0 : daddr_ff;
      sport_in = first_byte ? 16'd0 : sport_ff;
      dport_in = first_byte ? 16'd0 : dport_ff;
      base = mode ? EtherLen : 7'd0;
      q = pos - base;
      if (mode && (pos == 7'd12 || pos == 7'd13)) etype_in = {etype_in[7:0], data_byte};
      if (pos >= base) begin
         if (q == 7'd0) vl_in = data_byte;
         else if (q == 7'd9) proto_in = data_byte;
         else if (q >= 7'd12 && q <= 7'd15) saddr_in = {saddr_in[23:0], data_byte};
         else if (q >= 7'd16 && q <= 7'd19) daddr_in = {daddr_in[23:0], data_byte};
      end
      vl_cur = vl_in;
      ihl_b = {1'b0, vl_cur[3:0], 2'b00};
      t = q - ihl_b;
      if (pos >= base && q != 7'd0 && ihl_b >= 7'd20 && q >= ihl_b) begin
         if (t <= 7'd1) sport_in = {sport_in[7:0], data_byte};
         else if (t <= 7'd3) dport_in = {dport_in[7:0], data_byte};
      end
      offset_in = (pos < OffsetMax) ? pos + 7'd1 : pos;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_parse) begin
         offset_ff <= '0; etype_ff <= '0; vl_ff <= '0; proto_ff <= '0;
         saddr_ff <= '0; daddr_ff <= '0; sport_ff <= '0; dport_ff <= '0;
      end else if (cmd.take_byte) begin
         offset_ff <= offset_in; etype_ff <= etype_in; vl_ff <= vl_in;
         proto_ff <= proto_in; saddr_ff <= saddr_in; daddr_ff <= daddr_in;
         sport_ff <= sport_in; dport_ff <= dport_in;
      end
      if (reset) begin
         group_ff <= '0; length_ff <= '0; dir_ff <= 1'b0;
      end else if (cmd.take_byte && first_byte) begin
         group_ff <= group_id; length_ff <= packet_length; dir_ff <= direction;
      end
   end

   // usability checks on the completed header
   logic [7:0] need;
   logic [6:0] ihl_h;
   always_comb begin
      ihl_h = {1'b0, vl_ff[3:0], 2'b00};
      need = {1'b0, base} + {1'b0, ihl_h} + ((proto_ff == ProtoTcp) ? 8'd20 : 8'd8);
      usable = ({1'b0, offset_ff} >= {1'b0, base} + 8'd20)
         && (!mode || etype_ff == EtherTypeIpv4) && (vl_ff[7:4] == IpVersion)
         && (ihl_h >= 7'd20) && (proto_ff == ProtoTcp || proto_ff == ProtoUdp)
         && ({1'b0, offset_ff} >= need);
   end

   // linear scan over occupied entries, one read per step
   logic [EW-1:0] key;
   logic [63:0] sum;
   assign key = {group_ff, saddr_ff, daddr_ff, sport_ff, dport_ff, dir_ff, 64'd0};
   assign hit = (rd_ff[EW-1:64] == key[EW-1:64]);
   assign scan_end = (idx_ff >= count_ff);
   assign full = (count_ff == CW'(TABLE_DEPTH));
   assign stat = {usable, hit, scan_end, full};
   assign sum = rd_ff[63:0] + {44'd0, length_ff};

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else if (cmd.scan_start) idx_ff <= '0;
      else if (cmd.scan_next) idx_ff <= idx_ff + 1'b1;
   end
   always_ff @(posedge clock) begin
      rd_ff <= mem[idx_ff[AW-1:0]];
      if (cmd.write_add) mem[idx_ff[AW-1:0]] <= {rd_ff[EW-1:64], sum};
      else if (cmd.write_new && !full)
         mem[count_ff[AW-1:0]] <= {key[EW-1:64], 44'd0, length_ff};
   end
   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (cmd.write_new && !full) count_ff <= count_ff + 1'b1;
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         if (!usable) begin
            status_ff <= STATUS_IGNORED; total_ff <= '0;
         end else if (cmd.write_add) begin
            status_ff <= STATUS_ADDED; total_ff <= sum;
         end else if (full) begin
            status_ff <= STATUS_FULL; total_ff <= '0;
         end else begin
            status_ff <= STATUS_NEW; total_ff <= {44'd0, length_ff};
         end
      end
   end
   assign res_status = status_ff;
   assign res_total = total_ff;
   assign res_used = 17'(count_ff);
endmodule

// File: src/fba_control.sv
// controller state machine for byte intake, table scan and result
// depends on fba_pkg
`timescale 1ns / 1ps
module fba_control
   import fba_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   input  logic     last_byte,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output cmd_type  cmd,
   input  stat_type stat
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_PARSE;
      else state_ff <= state_in;
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_PARSE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take_byte = 1'b1;
               if (last_byte) state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.scan_start = 1'b1;
            if (!stat.usable) begin
               cmd.load_result = 1'b1;
               state_in = ST_RESULT;
            end else state_in = ST_WAIT;
         end
         ST_WAIT: state_in = ST_CHECK;
         ST_CHECK: begin
            if (stat.scan_end) begin
               cmd.write_new = 1'b1;
               cmd.load_result = 1'b1;
               state_in = ST_RESULT;
            end else if (stat.hit) begin
               cmd.write_add = 1'b1;
               cmd.load_result = 1'b1;
               state_in = ST_RESULT;
            end else begin
               cmd.scan_next = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_RESULT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.clear_parse = 1'b1;
               state_in = ST_PARSE;
            end
         end
         default: state_in = ST_PARSE;
      endcase
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_PARSE) |-> !req_tready) else $error("input taken while busy");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.write_add && cmd.write_new)) else $error("two table writes");
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |=> rsp_tvalid) else $error("result not shown");
endmodule

// File: src/flow_byte_accounting_unit.sv
// flow byte accounting unit: top level joining controller and datapath
// depends on fba_pkg, fba_control, fba_datapath
// header bytes are taken one per cycle; the result of a usable packet follows a linear scan
// that reads entries in order up to the matched index, or the whole occupied count on a miss;
// an ignored packet skips the scan; no byte is taken until the result is accepted
// synchronous reset clears parse state, held fields and the occupied count
`timescale 1ns / 1ps
module flow_byte_accounting_unit
   import fba_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // data_byte, group_id, packet_length, direction, pad
   input  logic        req_tlast,  // last_byte
   input  logic        req_tuser,  // first_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata   // status, flow_total, entries_used, pad
);
   logic mode_ff;
   cmd_type cmd;
   stat_type stat;
   logic [1:0] st;
   logic [63:0] tot;
   logic [16:0] used;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= 1'b0;
      else if (csr_we) mode_ff <= csr_wdata;
   end

   fba_control u_ctl (
      .clock, .reset, .req_tvalid, .last_byte(req_tlast), .req_tready,
      .rsp_tvalid, .rsp_tready, .cmd, .stat
   );

   fba_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock, .reset, .mode(mode_ff), .cmd, .stat,
      .data_byte(req_tdata[7:0]), .first_byte(req_tuser),
      .group_id(req_tdata[71:8]), .packet_length(req_tdata[91:72]),
      .direction(req_tdata[92]), .res_status(st), .res_total(tot), .res_used(used)
   );

   assign rsp_tdata = {5'd0, used, tot, st};
endmodule
